// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// same check, also evaluated while reset is asserted
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== design/tsv_pkg.sv =====
// ----------------------------------------------------------------------------
// tsv_pkg
// Types, constants and helper functions of the timestamp field validator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsv_pkg;

    // widths of the stored field state
    localparam int LEN_W  = 5;
    localparam int YEAR_W = 14;
    localparam int PAIR_W = 7;

    // default for the body length cap
    localparam int MAX_CHARS_DEF = 26;

    // body layout
    localparam logic [LEN_W-1:0] DATE_CHARS = 5'd8;
    localparam logic [LEN_W-1:0] BODY_LIMIT = 5'd21;
    localparam logic [LEN_W-1:0] DOT_POS    = 5'd14;

    // configuration register indexes
    localparam logic CFG_MIN_YEAR = 1'b0;
    localparam logic CFG_MAX_YEAR = 1'b1;

    // year limits after reset
    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1000;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd3000;

    // time limits
    localparam logic [PAIR_W-1:0] HOUR_MAX = 7'd23;
    localparam logic [PAIR_W-1:0] MIN_MAX  = 7'd59;

    // character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // field state carried between characters
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              closed;
        logic              err;
        logic [PAIR_W-1:0] cent;
        logic [PAIR_W-1:0] lo;
        logic [PAIR_W-1:0] mon;
        logic [PAIR_W-1:0] day;
        logic [PAIR_W-1:0] hour;
        logic [PAIR_W-1:0] minute;
        logic [PAIR_W-1:0] second;
    } field_state_t;

    // two-digit accumulate: v * 10 + d
    function automatic logic [PAIR_W-1:0] times_ten_add(logic [PAIR_W-1:0] v,
                                                        logic [3:0] d);
        logic [9:0] t;
        t = {v, 3'b000} + {2'b00, v, 1'b0} + {6'b000000, d};
        return t[PAIR_W-1:0];
    endfunction

    // days per month, month 1..12 (February allows 29)
    function automatic logic [4:0] days_in_month(logic [3:0] mon);
        logic [4:0] r;
        unique case (mon)
            4'd2:    r = 5'd29;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tsv_field_parser.sv =====
// ----------------------------------------------------------------------------
// tsv_field_parser
// Holds the field state and folds in one character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tsv_field_parser #(
    parameter int MAX_CHARS = tsv_pkg::MAX_CHARS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic                last,
    input  wire logic [7:0]          char_in,
    output tsv_pkg::field_state_t    state_next
);

    tsv_pkg::field_state_t state_reg;
    logic                  is_digit;
    logic                  is_end;
    logic [3:0]            digit_val;
    logic [tsv_pkg::LEN_W-1:0] pos;

    // character classes
    assign is_digit  = (char_in >= tsv_pkg::CH_0) && (char_in <= tsv_pkg::CH_9);
    assign digit_val = is_digit ? 4'(char_in - tsv_pkg::CH_0) : 4'd0;
    assign is_end    = (char_in == tsv_pkg::CH_NUL) || (char_in == tsv_pkg::CH_SPACE) ||
                       ((char_in >= tsv_pkg::CH_TAB) && (char_in <= tsv_pkg::CH_CR)) ||
                       (char_in == tsv_pkg::CH_PLUS) || (char_in == tsv_pkg::CH_MINUS);
    assign pos       = state_reg.len;

    // state after taking this character
    always_comb
    begin
        state_next = state_reg;
        if (!(state_reg.closed || (pos >= tsv_pkg::LEN_W'(MAX_CHARS))))
        begin
            if (is_end)
            begin
                state_next.closed = 1'b1;
            end
            else
            begin
                state_next.len = pos + 5'd1;
                if (pos < tsv_pkg::BODY_LIMIT)
                begin
                    priority if (pos == tsv_pkg::DOT_POS)
                    begin
                        if (char_in != tsv_pkg::CH_DOT)
                            state_next.err = 1'b1;
                    end
                    else if (!is_digit)
                        state_next.err = 1'b1;
                    else if (pos < 5'd2)
                        state_next.cent = tsv_pkg::times_ten_add(state_reg.cent, digit_val);
                    else if (pos < 5'd4)
                        state_next.lo = tsv_pkg::times_ten_add(state_reg.lo, digit_val);
                    else if (pos < 5'd6)
                        state_next.mon = tsv_pkg::times_ten_add(state_reg.mon, digit_val);
                    else if (pos < tsv_pkg::DATE_CHARS)
                        state_next.day = tsv_pkg::times_ten_add(state_reg.day, digit_val);
                    else if (pos < 5'd10)
                        state_next.hour = tsv_pkg::times_ten_add(state_reg.hour, digit_val);
                    else if (pos < 5'd12)
                        state_next.minute =
                            tsv_pkg::times_ten_add(state_reg.minute, digit_val);
                    else if (pos < 5'd14)
                        state_next.second =
                            tsv_pkg::times_ten_add(state_reg.second, digit_val);
                    // fraction digits are checked but not kept
                    else
                        state_next.second = state_reg.second;
                end
            end
        end
    end

    // field state register, cleared after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (take)
            state_reg <= last ? '0 : state_next;
    end

endmodule

`default_nettype wire

// ===== design/tsv_judge.sv =====
// ----------------------------------------------------------------------------
// tsv_judge
// Decides from a complete field state whether the timestamp is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tsv_judge (
    input  wire tsv_pkg::field_state_t      fs,
    input  wire logic [tsv_pkg::YEAR_W-1:0] min_year,
    input  wire logic [tsv_pkg::YEAR_W-1:0] max_year,
    output logic                           ok
);

    logic [tsv_pkg::PAIR_W-1:0] mon_e;
    logic [tsv_pkg::PAIR_W-1:0] day_e;
    logic [tsv_pkg::YEAR_W-1:0] year;
    logic                       shape_bad;
    logic                       leap;
    logic                       mon_ok;
    logic                       day_ok;

    // short dates default month and day to 1
    always_comb
    begin
        mon_e = fs.mon;
        day_e = fs.day;
        if ((fs.len == 5'd2) || (fs.len == 5'd4))
            mon_e = 7'd1;
        if ((fs.len == 5'd2) || (fs.len == 5'd4) || (fs.len == 5'd6))
            day_e = 7'd1;
    end

    // full year from century and low pair (low pair is zero for a century body)
    assign year = {1'b0, fs.cent, 6'b000000} + {2'b00, fs.cent, 5'b00000} +
                  {5'b00000, fs.cent, 2'b00} + {7'b0000000, fs.lo};

    // leap year from the two pairs: divisible by 100 means low pair zero
    assign leap = (fs.lo != 7'd0) ? (fs.lo[1:0] == 2'b00) : (fs.cent[1:0] == 2'b00);

    // body length shape: empty, odd date, or odd time length
    assign shape_bad = (fs.len == 5'd0) ||
                       ((fs.len < tsv_pkg::DATE_CHARS) && fs.len[0]) ||
                       (fs.len == 5'd9) || (fs.len == 5'd11) || (fs.len == 5'd13);

    // calendar checks
    assign mon_ok = (mon_e >= 7'd1) && (mon_e <= 7'd12);
    assign day_ok = (day_e >= 7'd1) &&
                    (day_e <= {2'b00, tsv_pkg::days_in_month(mon_e[3:0])}) &&
                    !((mon_e == 7'd2) && (day_e == 7'd29) && !leap);

    assign ok = !fs.err && !shape_bad && mon_ok && day_ok &&
                (year >= min_year) && (year <= max_year) &&
                (fs.hour <= tsv_pkg::HOUR_MAX) && (fs.minute <= tsv_pkg::MIN_MAX) &&
                (fs.second <= tsv_pkg::MIN_MAX);

endmodule

`default_nettype wire

// ===== design/timestamp_field_validator.sv =====
// ----------------------------------------------------------------------------
// timestamp_field_validator
// Checks a timestamp field streamed one character per transfer and returns
// one valid/invalid flag per field, after the character marked last.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------
//  input    | in_valid / in_ready  | char_in[7:0], last
//  output   | out_valid / out_ready| valid_res
//  config   | cfg_we               | cfg_index, cfg_data[13:0]
//
//  one character per cycle while in_ready is high; the field state register folds it in at the transfer
//  the flag is registered into the output buffer at the last character's transfer
//  a two-entry output buffer keeps taking characters while a flag waits;
//  in_ready drops only when both entries hold flags
//  reset is asynchronous: field state clears, limits return to 1000 and 3000
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_field_validator #(
    parameter int MAX_CHARS = tsv_pkg::MAX_CHARS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  char_in,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             valid_res,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [tsv_pkg::YEAR_W-1:0]  cfg_data
);

    logic                       take;
    logic                       push;
    logic                       pop;
    logic                       ok;
    tsv_pkg::field_state_t      state_next;
    logic [tsv_pkg::YEAR_W-1:0] min_year_reg;
    logic [tsv_pkg::YEAR_W-1:0] max_year_reg;
    logic                       out_v_reg, out_v_next;
    logic                       out_d_reg, out_d_next;
    logic                       skid_v_reg, skid_v_next;
    logic                       skid_d_reg, skid_d_next;

    // handshake
    assign in_ready  = !skid_v_reg;
    assign take      = in_valid && in_ready;
    assign push      = take && last;
    assign pop       = out_v_reg && out_ready;
    assign out_valid = out_v_reg;
    assign valid_res = out_d_reg;

    // year limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= tsv_pkg::MIN_YEAR_RST;
            max_year_reg <= tsv_pkg::MAX_YEAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsv_pkg::CFG_MIN_YEAR: min_year_reg <= cfg_data;
                tsv_pkg::CFG_MAX_YEAR: max_year_reg <= cfg_data;
            endcase
        end
    end

    // field state and character folding
    tsv_field_parser #(
        .MAX_CHARS (MAX_CHARS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .last       (last),
        .char_in    (char_in),
        .state_next (state_next)
    );

    // verdict on the state including the last character
    tsv_judge u_judge (
        .fs       (state_next),
        .min_year (min_year_reg),
        .max_year (max_year_reg),
        .ok       (ok)
    );

    // two-entry output buffer, oldest flag in the output register
    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (pop)
        begin
            if (skid_v_reg)
            begin
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
            else
                out_v_next = 1'b0;
        end
        if (push)
        begin
            if (!out_v_next)
            begin
                out_v_next = 1'b1;
                out_d_next = ok;
            end
            else
            begin
                skid_v_next = 1'b1;
                skid_d_next = ok;
            end
        end
    end

    // buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // buffer payload
    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

endmodule

`default_nettype wire

// ===== design/tsv_checker.sv =====
// ----------------------------------------------------------------------------
// tsv_checker
// Port-level checks on the validator's flow control, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tsv_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       last,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       valid_res
);

    logic last_xfer;

    // transfer of the last character of a field
    assign last_xfer = in_valid && in_ready && last;

    // a waiting flag holds until its transfer
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(valid_res))

    // out_valid is high in the cycle after the last character's transfer
    `ASSERT_CLK(a_flag_follows, clk, rst_n, last_xfer |=> out_valid)

    // a second flag behind a stalled one fills the buffer
    `ASSERT_CLK(a_buffer_full, clk, rst_n, out_valid && !out_ready && last_xfer |=> !in_ready)

    // input stalls only while flags are waiting
    `ASSERT_ALWAYS(a_stall_cause, clk, !in_ready |-> out_valid)

endmodule

bind timestamp_field_validator tsv_checker u_tsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .valid_res (valid_res)
);

`default_nettype wire

// ===== bench/timestamp_field_validator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamp_field_validator_test
// Streams timestamp fields into the validator one character per transfer and
// compares every returned flag with a flag worked out in the bench.
// Directed fields cover the date and time forms and the year limits. Random
// fields follow under changing year limits, sender gaps and receiver stalls,
// and a long receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------

module timestamp_field_validator_test;

    // field layout and bench limits
    localparam int MAX_CHARS   = tsv_pkg::MAX_CHARS_DEF;
    localparam int DATE_LEN    = 8;
    localparam int BODY_END    = 21;
    localparam int DOT_AT      = 14;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 4;
    localparam int PHASE_CHARS = 30;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 char_in = 8'h00;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       valid_res;
    logic                       cfg_we = 1'b0;
    logic                       cfg_index = tsv_pkg::CFG_MIN_YEAR;
    logic [tsv_pkg::YEAR_W-1:0] cfg_data = '0;

    // year limits as the block should hold them
    int unsigned min_year_cfg = 1000;
    int unsigned max_year_cfg = 3000;

    // field state folded from accepted characters
    int unsigned                 body_len = 0;
    bit                          body_closed = 1'b0;
    bit                          body_err = 1'b0;
    bit [tsv_pkg::YEAR_W-1:0]    year_acc = '0;
    bit [tsv_pkg::PAIR_W-1:0]    month_acc = '0;
    bit [tsv_pkg::PAIR_W-1:0]    day_acc = '0;
    bit [tsv_pkg::PAIR_W-1:0]    hour_acc = '0;
    bit [tsv_pkg::PAIR_W-1:0]    minute_acc = '0;
    bit [tsv_pkg::PAIR_W-1:0]    second_acc = '0;

    int unsigned month_days[12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    bit          pending_flags[$];
    logic [7:0]  field_chars[$];
    int          mismatch_count = 0;
    int          flags_seen = 0;
    int          sent_chars = 0;
    int          idle_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    timestamp_field_validator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // clear the field state after each flag
    function automatic void clear_field();
        body_len    = 0;
        body_closed = 1'b0;
        body_err    = 1'b0;
        year_acc    = '0;
        month_acc   = '0;
        day_acc     = '0;
        hour_acc    = '0;
        minute_acc  = '0;
        second_acc  = '0;
    endfunction

    // fold one accepted character into the field state
    function automatic void fold_char(logic [7:0] c);
        int unsigned pos;
        bit          is_digit;
        int unsigned d;
        pos      = body_len;
        is_digit = (c >= "0") && (c <= "9");
        d        = is_digit ? c - "0" : 0;
        if (body_closed || pos >= MAX_CHARS)
            return;
        // whitespace, sign or nul closes the body
        if (c == 8'h00 || c == " " || (c >= 8'h09 && c <= 8'h0d) || c == "+" || c == "-")
        begin
            body_closed = 1'b1;
            return;
        end
        body_len = pos + 1;
        if (pos >= BODY_END)
            return;
        if (pos == DOT_AT)
        begin
            if (c != ".")
                body_err = 1'b1;
            return;
        end
        if (!is_digit)
        begin
            body_err = 1'b1;
            return;
        end
        if (pos < 4)
            year_acc = tsv_pkg::YEAR_W'(year_acc * 10 + d);
        else if (pos < 6)
            month_acc = tsv_pkg::PAIR_W'(month_acc * 10 + d);
        else if (pos < 8)
            day_acc = tsv_pkg::PAIR_W'(day_acc * 10 + d);
        else if (pos < 10)
            hour_acc = tsv_pkg::PAIR_W'(hour_acc * 10 + d);
        else if (pos < 12)
            minute_acc = tsv_pkg::PAIR_W'(minute_acc * 10 + d);
        else if (pos < 14)
            second_acc = tsv_pkg::PAIR_W'(second_acc * 10 + d);
    endfunction

    // flag for the field folded so far
    function automatic bit timestamp_ok();
        int unsigned len;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned tl;
        bit          leap;
        len = body_len;
        yr  = year_acc;
        mo  = month_acc;
        dy  = day_acc;
        if (body_err)
            return 1'b0;
        if (len == 0 || (len < DATE_LEN && (len % 2) != 0))
            return 1'b0;
        // short dates: century, year, year and month
        if (len == 2)
        begin
            yr = yr * 100;
            mo = 1;
            dy = 1;
        end
        else if (len == 4)
        begin
            mo = 1;
            dy = 1;
        end
        else if (len == 6)
            dy = 1;
        if (len > DATE_LEN)
        begin
            tl = (len > BODY_END ? BODY_END : len) - DATE_LEN;
            if (tl == 1 || tl == 3 || tl == 5)
                return 1'b0;
        end
        if (mo < 1 || mo > 12)
            return 1'b0;
        if (dy < 1 || dy > month_days[mo-1])
            return 1'b0;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        if (mo == 2 && dy == 29 && !leap)
            return 1'b0;
        if (yr < min_year_cfg || yr > max_year_cfg)
            return 1'b0;
        if (hour_acc > 23 || minute_acc > 59 || second_acc > 59)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at flag %0d: %s", flags_seen, what);
        mismatch_count++;
    endtask

    // input transfers feed the flag predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready === 1'b1)
        begin
            fold_char(char_in);
            if (last)
            begin
                pending_flags.push_back(timestamp_ok());
                clear_field();
            end
        end
    end

    // output transfers are checked against the oldest pending flag
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_flags.size() == 0)
                report_mismatch("flag with no field pending");
            else
            begin
                want = pending_flags.pop_front();
                if (valid_res !== want)
                    report_mismatch($sformatf("valid_res %b, wanted %b", valid_res, want));
            end
            flags_seen++;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // offer one character, with random gaps before it
    task automatic send_char(logic [7:0] c, logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        last     <= is_last;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic send_field();
        int n;
        n = field_chars.size();
        for (int i = 0; i < n; i++)
            send_char(field_chars[i], i == n - 1);
        sent_chars += n;
    endtask

    task automatic send_text(string s);
        field_chars.delete();
        for (int i = 0; i < s.len(); i++)
            field_chars.push_back(s[i]);
        send_field();
    endtask

    // stop offering and wait until every flag has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        // let the last input transfer reach the predictor first
        @(posedge clk);
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write both year limits while the block is idle
    task automatic set_year_range(int unsigned lo, int unsigned hi);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= tsv_pkg::CFG_MIN_YEAR;
        cfg_data  <= tsv_pkg::YEAR_W'(lo);
        @(posedge clk);
        cfg_index <= tsv_pkg::CFG_MAX_YEAR;
        cfg_data  <= tsv_pkg::YEAR_W'(hi);
        @(posedge clk);
        cfg_we <= 1'b0;
        min_year_cfg = lo;
        max_year_cfg = hi;
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // append a number as n decimal digits
    function automatic void put_num(int unsigned v, int n);
        int unsigned scale;
        scale = 1;
        for (int i = 1; i < n; i++)
            scale *= 10;
        for (int i = 0; i < n; i++)
        begin
            field_chars.push_back(8'(tsv_pkg::CH_0 + (v / scale) % 10));
            scale /= 10;
        end
    endfunction

    // mostly well-formed timestamps with random content, some noise
    function automatic void make_random_field();
        int unsigned dlen;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned n;
        field_chars.delete();
        // pure noise over the whole byte range
        if ($urandom_range(99) < 15)
        begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
                field_chars.push_back(8'($urandom_range(255)));
            return;
        end
        // date
        if (min_year_cfg <= max_year_cfg && $urandom_range(1))
            yr = $urandom_range(min_year_cfg, max_year_cfg);
        else
            yr = $urandom_range(9999);
        mo = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12);
        if ($urandom_range(9) == 0)
        begin
            mo = 2;
            dy = 29;
        end
        else if ($urandom_range(9) == 0)
            dy = $urandom_range(99);
        else
            dy = $urandom_range(1, (mo >= 1 && mo <= 12) ? month_days[mo-1] + 1 : 31);
        put_num(yr, 4);
        put_num(mo, 2);
        put_num(dy, 2);
        case ($urandom_range(9))
            0:       dlen = 2;
            1:       dlen = 4;
            2:       dlen = 6;
            3:       dlen = 2 * $urandom_range(3) + 1;
            default: dlen = 8;
        endcase
        while (field_chars.size() > dlen)
            void'(field_chars.pop_back());
        // time, with occasional out-of-range parts
        if (dlen == 8 && $urandom_range(4) != 0)
        begin
            put_num(($urandom_range(7) == 0) ? $urandom_range(24, 99) : $urandom_range(23), 2);
            put_num(($urandom_range(7) == 0) ? $urandom_range(60, 99) : $urandom_range(59), 2);
            put_num(($urandom_range(7) == 0) ? $urandom_range(60, 99) : $urandom_range(59), 2);
            case ($urandom_range(4))
                0:
                begin
                    field_chars.push_back(".");
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                        put_num($urandom_range(9), 1);
                end
                1: n = $urandom_range(1, 5);
                2: n = 2 * $urandom_range(1, 3);
                default: n = 6;
            endcase
            while (field_chars.size() > DATE_LEN + n && field_chars.size() <= DATE_LEN + 6)
                void'(field_chars.pop_back());
        end
        // offset or trailing junk
        case ($urandom_range(3))
            0:
            begin
                field_chars.push_back($urandom_range(1) ? "+" : "-");
                put_num($urandom_range(2359), 4);
            end
            1:
            begin
                field_chars.push_back($urandom_range(1) ? " " : tsv_pkg::CH_TAB);
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    field_chars.push_back(8'($urandom_range(255)));
            end
            default: ;
        endcase
        // occasional corrupted character
        if ($urandom_range(9) == 0)
            field_chars[$urandom_range(field_chars.size() - 1)] = 8'($urandom_range(255));
    endfunction

    // date forms under the limits after reset
    task automatic test_date_forms();
        set_idling(0, 0);
        send_text("2024");
        send_text("20");
        send_text("202412");
        send_text("20240229");
        send_text("21000229");
        send_text("20000229");
        send_text("202");
        send_text("2024011");
        send_text("+");
        send_text("202413");
        send_text("20240431");
        send_text("20241231");
        send_text("20240100");
        send_text("0999");
        send_text("3001");
        wait_drained();
    endtask

    // time forms, offsets and the body length cap
    task automatic test_time_forms();
        set_idling(0, 0);
        send_text("2024010123");
        send_text("202401011");
        send_text("20240101235959.1234-0500");
        send_text("2024010124");
        send_text("202401012360");
        send_text("20240101235960");
        send_text("20240101120000x1");
        send_text("2024010112a0");
        send_text("20240101120000.123456XYZabc");
        send_text("2024\tx");
        field_chars = '{"2", "0", "2", "4", tsv_pkg::CH_NUL, "x"};
        send_field();
        wait_drained();
    endtask

    // year limits at their extremes, including an empty range
    task automatic test_year_range();
        set_idling(0, 0);
        set_year_range(0, 9999);
        send_text("0000");
        send_text("99");
        send_text("9999");
        set_year_range(2001, 2000);
        send_text("2000");
        set_year_range(0, 0);
        send_text("0000");
        send_text("0001");
        set_year_range(9999, 9999);
        send_text("9999");
        set_year_range(4200, 8191);
        send_text("8191");
        send_text("4199");
        wait_drained();
    endtask

    // random fields across idling phases and year limits
    task automatic test_random_fields();
        int unsigned send_pcts[4] = '{0, 49, 0, 21};
        int unsigned recv_pcts[4] = '{0, 0, 49, 21};
        int          phase_start;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_year_range(1000, 3000);
                1:       set_year_range(0, 9999);
                2:       set_year_range(1900, 2100);
                default: set_year_range($urandom_range(9999), $urandom_range(9999));
            endcase
            set_idling(send_pcts[ph], recv_pcts[ph]);
            phase_start = sent_chars;
            while (sent_chars - phase_start < PHASE_CHARS)
            begin
                make_random_field();
                send_field();
            end
            wait_drained();
        end
    endtask

    // long receiver hold-off while short fields keep coming
    task automatic test_backpressure();
        set_idling(0, 0);
        set_year_range(1000, 3000);
        hold_token++;
        for (int k = 0; k < 30; k++)
            send_text((k % 2) ? "2024" : "1999x");
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_date_forms();
        test_time_forms();
        test_year_range();
        test_random_fields();
        test_backpressure();
        wait_drained();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/tsv_pkg.sv
design/tsv_field_parser.sv
design/tsv_judge.sv
design/timestamp_field_validator.sv
design/tsv_checker.sv
bench/timestamp_field_validator_test.sv
